>>> design/udiv_pkg.sv
// udiv_pkg: shared types for the unsigned divider
// holds the controller state enum and the controller-to-datapath command struct
// no dependencies
package udiv_pkg;

   typedef enum logic [0:0] {
      ST_IDLE = 1'b0,
      ST_RUN  = 1'b1
   } state_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;     // capture a new word from the request channel
      logic step;     // run one shift-and-subtract step
      logic out_load; // copy the step result into the response register
   } cmd_type;

endpackage

>>> design/udiv_ctrl.sv
// udiv_ctrl: state machine of the unsigned divider
// sequences load, one step per cycle (the last waits for a free response slot) and response hand-off
// depends on udiv_pkg
module udiv_ctrl
   import udiv_pkg::*;
#(
   parameter int DATA_WIDTH = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output cmd_type cmd
);

   localparam int CntW = (DATA_WIDTH > 2) ? $clog2(DATA_WIDTH) : 1;
   localparam logic [CntW-1:0] LastStep = CntW'(DATA_WIDTH - 1);

   state_type       state_ff, state_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            out_valid_ff, out_valid_in;
   logic            slot_free;

   // response slot is free or is being emptied this cycle
   assign slot_free = !out_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      cmd          = '0;
      req_stall    = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (cnt_ff != LastStep) begin
               cmd.step = 1'b1;
               cnt_in   = cnt_ff + 1'b1;
            end else if (slot_free) begin
               // last step goes straight into the response register
               cmd.step     = 1'b1;
               cmd.out_load = 1'b1;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = out_valid_ff;

endmodule

>>> design/udiv_datapath.sv
// udiv_datapath: registers and subtractor of the restoring divider
// one quotient bit per step, response register at the end
// depends on udiv_pkg
module udiv_datapath
   import udiv_pkg::*;
#(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  cmd_type               cmd,
   input  logic [DATA_WIDTH-1:0] req_dividend,
   input  logic [DATA_WIDTH-1:0] req_divisor,
   output logic [DATA_WIDTH-1:0] rsp_quotient,
   output logic [DATA_WIDTH-1:0] rsp_remainder,
   output logic                  rsp_divide_by_zero
);

   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic [DATA_WIDTH-1:0] quo_ff, quo_in;   // dividend bits shift out, quotient bits in
   logic [DATA_WIDTH-1:0] div_ff;
   logic                  dbz_ff;
   logic [DATA_WIDTH-1:0] oq_ff, or_ff;
   logic                  odbz_ff;
   logic [DATA_WIDTH:0]   partial, diff;
   logic                  fits;

   always_comb begin
      partial = {rem_ff, quo_ff[DATA_WIDTH-1]};
      diff    = partial - {1'b0, div_ff};
      fits    = !diff[DATA_WIDTH];
      rem_in  = fits ? diff[DATA_WIDTH-1:0] : partial[DATA_WIDTH-1:0];
      quo_in  = {quo_ff[DATA_WIDTH-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rem_ff <= '0;
         quo_ff <= req_dividend;
         div_ff <= req_divisor;
         dbz_ff <= (req_divisor == '0);
      end else if (cmd.step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
      if (cmd.out_load) begin
         oq_ff   <= quo_in;
         or_ff   <= rem_in;
         odbz_ff <= dbz_ff;
      end
   end

   assign rsp_quotient       = oq_ff;
   assign rsp_remainder      = or_ff;
   assign rsp_divide_by_zero = odbz_ff;

endmodule

>>> design/unsigned_divider.sv
// unsigned_divider: iterative restoring divider, quotient and remainder
// throughput: one word at a time, set by the single shared subtractor
// a zero divisor needs no special path: every step fits, giving all ones and the dividend
// reset: synchronous, active high, clears controller state and response valid
// depends on udiv_pkg, udiv_ctrl, udiv_datapath
module unsigned_divider
   import udiv_pkg::*;
#(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [DATA_WIDTH-1:0] req_dividend,
   input  logic [DATA_WIDTH-1:0] req_divisor,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [DATA_WIDTH-1:0] rsp_quotient,
   output logic [DATA_WIDTH-1:0] rsp_remainder,
   output logic                  rsp_divide_by_zero
);

   cmd_type cmd;

   // controller: idle -> one step per cycle (last may stall) -> hand-off into response register
   udiv_ctrl #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // datapath: partial remainder, shifting quotient and response register
   udiv_datapath #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_dp (
      .clock              (clock),
      .cmd                (cmd),
      .req_dividend       (req_dividend),
      .req_divisor        (req_divisor),
      .rsp_quotient       (rsp_quotient),
      .rsp_remainder      (rsp_remainder),
      .rsp_divide_by_zero (rsp_divide_by_zero)
   );

   // a word taken in keeps the request side closed while it is worked on
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while divider busy");

   // divide by zero always shows an all-ones quotient
   a_dbz_quotient: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_divide_by_zero) |-> (rsp_quotient == '1))
      else $error("divide by zero without all-ones quotient");

   // a new response only appears at the end of a run
   a_rsp_from_run: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response appeared without a division in progress");

endmodule

>>> tb/sv/udiv_checker.sv
`timescale 1ns / 1ps
// udiv_checker: watches the request and response channels of unsigned_divider
// predicts quotient, remainder and divide-by-zero flag per word and compares in order
// no dependencies beyond the dut port list
module udiv_checker #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [DATA_WIDTH-1:0] req_dividend,
   input  logic [DATA_WIDTH-1:0] req_divisor,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [DATA_WIDTH-1:0] rsp_quotient,
   input  logic [DATA_WIDTH-1:0] rsp_remainder,
   input  logic                  rsp_divide_by_zero,
   output int                    mismatch_count,
   output int                    words_pending
);

   typedef struct packed {
      logic [DATA_WIDTH-1:0] quotient;
      logic [DATA_WIDTH-1:0] remainder;
      logic                  divide_by_zero;
   } division_result_type;

   division_result_type expected_results[$];

   initial begin
      mismatch_count = 0;
      words_pending  = 0;
   end

   function automatic int significant_bits(input logic [DATA_WIDTH-1:0] v);
      int n;
      n = 0;
      for (int i = 0; i < DATA_WIDTH; i++) begin
         if (v[i]) n = i + 1;
      end
      return n;
   endfunction

   // shift-and-subtract with the divisor aligned to the dividend's leading one
   function automatic division_result_type restoring_divide(
         input logic [DATA_WIDTH-1:0] num,
         input logic [DATA_WIDTH-1:0] den);
      division_result_type   r;
      logic [DATA_WIDTH-1:0] aligned;
      int                    shift;
      r.quotient       = '0;
      r.remainder      = num;
      r.divide_by_zero = 1'b0;
      if (den == '0) begin
         r.quotient       = '1;
         r.divide_by_zero = 1'b1;
      end else if (den <= num) begin
         shift   = significant_bits(num) - significant_bits(den);
         aligned = den << shift;
         for (int i = 0; i <= shift; i++) begin
            r.quotient = r.quotient << 1;
            if (r.remainder >= aligned) begin
               r.quotient[0] = 1'b1;
               r.remainder   = r.remainder - aligned;
            end
            aligned = aligned >> 1;
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [DATA_WIDTH-1:0] got,
                                  input logic [DATA_WIDTH-1:0] want);
      $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $time);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      division_result_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected word, quotient", rsp_quotient, '0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_quotient !== want.quotient)
                  report_mismatch("quotient", rsp_quotient, want.quotient);
               if (rsp_remainder !== want.remainder)
                  report_mismatch("remainder", rsp_remainder, want.remainder);
               if (rsp_divide_by_zero !== want.divide_by_zero)
                  report_mismatch("divide_by_zero", DATA_WIDTH'(rsp_divide_by_zero),
                                  DATA_WIDTH'(want.divide_by_zero));
            end
         end
         if (req_valid && !req_stall)
            expected_results.push_back(restoring_divide(req_dividend, req_divisor));
         words_pending = expected_results.size();
      end
   end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// tb: top of the unsigned_divider regression, drives requests and response stalls
// depends on unsigned_divider and udiv_checker, which predicts and compares
module tb;

   localparam int DATA_WIDTH   = 32;
   localparam int LATENCY      = DATA_WIDTH + 1;
   localparam int RANDOM_WORDS = 1430;
   // the slowest legal run still finishes far inside this limit, so this leaves lots of margin
   localparam int CYCLE_LIMIT  = 500000;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [DATA_WIDTH-1:0] req_dividend;
   logic [DATA_WIDTH-1:0] req_divisor;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [DATA_WIDTH-1:0] rsp_quotient;
   logic [DATA_WIDTH-1:0] rsp_remainder;
   logic                  rsp_divide_by_zero;

   int mismatch_count;
   int words_pending;
   int words_sent;
   bit calm;          // set near the end: no idling on either side
   int gap_percent;   // sender idle chance, re-rolled every so often

   unsigned_divider #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_dividend      (req_dividend),
      .req_divisor       (req_divisor),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_quotient      (rsp_quotient),
      .rsp_remainder     (rsp_remainder),
      .rsp_divide_by_zero(rsp_divide_by_zero)
   );

   udiv_checker #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_dividend      (req_dividend),
      .req_divisor       (req_divisor),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_quotient      (rsp_quotient),
      .rsp_remainder     (rsp_remainder),
      .rsp_divide_by_zero(rsp_divide_by_zero),
      .mismatch_count    (mismatch_count),
      .words_pending     (words_pending)
   );

   // 2 ns clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // every input known from time zero, reset held high at the start
   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_dividend = '0;
      req_divisor  = '0;
      rsp_stall    = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   // watchdog
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("unsigned_divider regression: fail");
      $finish;
   end

   // a random-length burst of idle cycles on the request side
   task automatic sender_gap();
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clock);
   endtask

   // present one word and hold it until the divider takes it
   task automatic offer_word(input logic [DATA_WIDTH-1:0] dividend,
                             input logic [DATA_WIDTH-1:0] divisor);
      if (!calm && $urandom_range(0, 99) < gap_percent) sender_gap();
      req_valid    <= 1'b1;
      req_dividend <= dividend;
      req_divisor  <= divisor;
      // valid is high from the next edge on; accepted at the first edge with stall low
      do @(posedge clock); while (req_stall);
      words_sent++;
   endtask

   // operand with nbits significant bits, random low bits, leading one forced
   function automatic logic [DATA_WIDTH-1:0] sized_operand(input int nbits);
      logic [DATA_WIDTH-1:0] v;
      v = DATA_WIDTH'({$urandom, $urandom});
      if (nbits <= 0) return '0;
      if (nbits < DATA_WIDTH) v = v >> (DATA_WIDTH - nbits);
      v[nbits-1] = 1'b1;
      return v;
   endfunction

   // request side: directed corners, then shaped random words
   initial begin
      logic [DATA_WIDTH-1:0] num;
      logic [DATA_WIDTH-1:0] den;
      int                    shape;
      words_sent  = 0;
      calm        = 1'b0;
      gap_percent = 30;
      @(posedge clock);
      while (reset) @(posedge clock);

      // zero divisor, with zero, all-ones and an ordinary dividend
      offer_word('0, '0);
      offer_word('1, '0);
      offer_word(32'h1234_5678, '0);
      // divisor of one and divisor equal to dividend
      offer_word('0, 32'd1);
      offer_word('1, 32'd1);
      offer_word(32'd1, 32'd1);
      offer_word(32'd7, 32'd7);
      offer_word('1, '1);
      offer_word(32'h8000_0000, 32'h8000_0000);
      // divisor larger than dividend
      offer_word('0, '1);
      offer_word(32'd1, '1);
      offer_word(32'd5, 32'd7);
      offer_word(32'hffff_fffe, '1);
      offer_word(32'h7fff_ffff, 32'h8000_0000);
      offer_word(32'h5555_5555, 32'haaaa_aaaa);
      // widest alignment shifts and ordinary cases
      offer_word(32'h8000_0000, 32'd1);
      offer_word('1, 32'h8000_0000);
      offer_word('1, 32'd3);
      offer_word(32'd100, 32'd7);
      offer_word(32'haaaa_aaaa, 32'h5555_5555);

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 100 == 0) gap_percent = $urandom_range(0, 50);
         if (n == RANDOM_WORDS - 200) calm = 1'b1;
         shape = $urandom_range(0, 15);
         case (shape)
            0: begin
               // zero divisor
               num = sized_operand($urandom_range(0, DATA_WIDTH));
               den = '0;
            end
            1: begin
               // equal operands
               num = sized_operand($urandom_range(1, DATA_WIDTH));
               den = num;
            end
            2: begin
               // exact multiple, zero remainder
               den = sized_operand($urandom_range(1, DATA_WIDTH / 2));
               num = den * sized_operand($urandom_range(1, DATA_WIDTH / 2));
            end
            3: begin
               // divisor larger than dividend
               num = sized_operand($urandom_range(0, DATA_WIDTH - 1));
               den = sized_operand($urandom_range(1, DATA_WIDTH));
               if (den <= num) den = num + 1'b1;
            end
            4, 5: begin
               // full-width raw bits
               num = $urandom;
               den = $urandom;
            end
            default: begin
               // random bit lengths for both, so every alignment shift shows up
               num = sized_operand($urandom_range(0, DATA_WIDTH));
               den = sized_operand($urandom_range(1, DATA_WIDTH));
            end
         endcase
         offer_word(num, den);
      end
      req_valid <= 1'b0;

      // drain, then let the divider settle before the final check
      while (words_pending != 0) @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
      if (mismatch_count == 0 && words_pending == 0) begin
         $display("unsigned_divider regression: pass");
      end else begin
         $display("unsigned_divider regression: fail");
      end
      $finish;
   end

   // response side: random stall bursts, one long hold-off, none in the calm tail
   initial begin
      bit long_hold_done;
      long_hold_done = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!long_hold_done && words_sent >= 25) begin
            // hold off long enough that the divider backs up into req_stall
            long_hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (300) @(posedge clock);
         end else if (calm) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end
      end
   end

endmodule

>>> filelist.f
design/udiv_pkg.sv
design/udiv_ctrl.sv
design/udiv_datapath.sv
design/unsigned_divider.sv
tb/sv/udiv_checker.sv
tb/sv/tb.sv
